/* rtl/core/packed_2bit_by_4bit_dot_product_defines.svh */
// Assertion macros shared by the dot product block.
`ifndef PACKED_2BIT_BY_4BIT_DOT_PRODUCT_DEFINES_SVH
`define PACKED_2BIT_BY_4BIT_DOT_PRODUCT_DEFINES_SVH

// Checked property that is switched off while reset is asserted.
`define PDP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dot product assertion failed");

// Checked property that is also evaluated during reset.
`define PDP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("dot product assertion failed");

`endif

/* rtl/core/pdp_pkg.sv */
// Types and constants shared by the dot product block.
package pdp_pkg;

    localparam int CFG_W      = 11;
    localparam int QIDX_W     = 12;
    localparam int QVAL_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int SUM_W      = 18;
    localparam int PAIR_W     = 2;
    localparam int NUM_PAIRS  = 4;
    localparam int PROD_W     = PAIR_W + QVAL_W;
    localparam int ADD_W      = PROD_W + 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SUM_W-1:0]  SUM_MAX   = 18'h3FFFF;
    localparam logic [PAIR_W-1:0] PAIR_MASK = 2'h3;

    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_DOC   = 1'b1;

    // One classified item as it waits between the front and the back.
    typedef struct packed {
        logic                  is_doc;
        logic                  wr_en;
        logic [QIDX_W-1:0]     qidx;
        logic [QVAL_W-1:0]     qval;
        logic [BYTE_W-1:0]     doc_byte;
    } t_op;

endpackage

/* rtl/core/pdp_front.sv */
// Front end: accepts items, classifies them and queues them for the back end.
module pdp_front #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_func,
    input  logic [pdp_pkg::QIDX_W-1:0] i_query_index,
    input  logic [pdp_pkg::QVAL_W-1:0] i_query_value,
    input  logic [pdp_pkg::BYTE_W-1:0] i_doc_byte,
    output logic                       o_op_valid,
    output pdp_pkg::t_op               o_op,
    input  logic                       i_op_pop
);

    localparam int D     = pdp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (D > 1) ? $clog2(D) : 1;
    localparam int CNT_W = $clog2(D + 1);

    pdp_pkg::t_op       w_op;
    pdp_pkg::t_op       r_q_op [D];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_push;

    // Query writes outside the store are flagged here and dropped by the back end.
    always_comb begin
        w_op.is_doc   = (i_func == pdp_pkg::FUNC_DOC);
        w_op.wr_en    = (i_func == pdp_pkg::FUNC_QUERY) &&
                        (32'(i_query_index) < 32'(STORE_DEPTH));
        w_op.qidx     = i_query_index;
        w_op.qval     = i_query_value;
        w_op.doc_byte = i_doc_byte;
    end

    assign o_ready    = (r_count != CNT_W'(D));
    assign w_push     = i_valid && o_ready;
    assign o_op_valid = (r_count != '0);
    assign o_op       = r_q_op[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(D - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_op_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(D - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !i_op_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_op_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_op[r_wr_ptr] <= w_op;
        end
    end

endmodule

/* rtl/core/pdp_back.sv */
// Back end: query store, position tracking, accumulation and the result register.
`include "packed_2bit_by_4bit_dot_product_defines.svh"

module pdp_back #(
    parameter int MAX_DOC_BYTES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [$clog2(MAX_DOC_BYTES+1)-1:0] i_len,
    input  logic                       i_op_valid,
    input  pdp_pkg::t_op               i_op,
    output logic                       o_op_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [pdp_pkg::SUM_W-1:0]  o_dot_product
);

    localparam int STORE_DEPTH = 4 * MAX_DOC_BYTES;
    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int POS_W = (MAX_DOC_BYTES > 1) ? $clog2(MAX_DOC_BYTES) : 1;
    localparam int NP    = pdp_pkg::NUM_PAIRS;
    localparam int SW    = pdp_pkg::SUM_W;

    logic [POS_W-1:0]                r_pos, n_pos;
    logic                            w_last;
    logic                            w_wr_en;
    logic                            w_rd_en;
    logic [AW-1:0]                   w_wr_addr;
    logic [AW-1:0]                   w_rd_addr [NP];

    // Stage B holds a document byte whose store reads are in flight.
    logic                            r_b_valid;
    logic                            r_b_last;
    logic [pdp_pkg::BYTE_W-1:0]      r_b_byte;
    logic                            w_b_adv;
    logic [pdp_pkg::PROD_W-1:0]      w_prod [NP];
    logic [pdp_pkg::ADD_W-1:0]       w_add;
    logic [SW:0]                     w_sum_wide;
    logic [SW-1:0]                   w_sum;
    logic [SW-1:0]                   r_sum;

    logic                            r_out_valid;
    logic [SW-1:0]                   r_out_data;

    assign w_b_adv  = r_b_valid && (!r_b_last || !r_out_valid || i_ready);
    assign o_op_pop = i_op_valid && (!r_b_valid || w_b_adv);
    assign w_wr_en  = o_op_pop && !i_op.is_doc && i_op.wr_en;
    assign w_rd_en  = o_op_pop && i_op.is_doc;
    assign w_wr_addr = AW'(i_op.qidx);
    assign w_last   = ((32'(r_pos) + 32'd1) >= 32'(i_len));

    // Stripe k of the query starts at k times the document length.
    always_comb begin
        for (int k = 0; k < NP; k++) begin
            w_rd_addr[k] = AW'(k) * AW'(i_len) + AW'(r_pos);
        end
    end

    // Each lane keeps its own copy of the store so all four reads run at once.
    for (genvar k = 0; k < NP; k++) begin : g_lane
        logic [pdp_pkg::QVAL_W-1:0] r_mem [STORE_DEPTH];
        logic [pdp_pkg::QVAL_W-1:0] r_rd_q;
        logic [pdp_pkg::PAIR_W-1:0] w_pair;

        always_ff @(posedge i_clk) begin
            if (w_wr_en) begin
                r_mem[w_wr_addr] <= i_op.qval;
            end
            if (w_rd_en) begin
                r_rd_q <= r_mem[w_rd_addr[k]];
            end
        end

        assign w_pair = r_b_byte[pdp_pkg::BYTE_W-1-pdp_pkg::PAIR_W*k -: pdp_pkg::PAIR_W]
                        & pdp_pkg::PAIR_MASK;
        assign w_prod[k] = pdp_pkg::PROD_W'(w_pair) * pdp_pkg::PROD_W'(r_rd_q);
    end

    always_comb begin
        w_add = '0;
        for (int k = 0; k < NP; k++) begin
            w_add = w_add + pdp_pkg::ADD_W'(w_prod[k]);
        end
        w_sum_wide = {1'b0, r_sum} + (SW + 1)'(w_add);
        w_sum      = w_sum_wide[SW] ? pdp_pkg::SUM_MAX : w_sum_wide[SW-1:0];
    end

    always_comb begin
        n_pos = r_pos;
        if (w_rd_en) begin
            n_pos = w_last ? '0 : POS_W'(32'(r_pos) + 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_b_valid   <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (o_op_pop) begin
                r_b_valid <= i_op.is_doc;
            end else if (w_b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (w_b_adv) begin
                r_sum <= r_b_last ? '0 : w_sum;
            end
            if (w_b_adv && r_b_last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_b_byte <= i_op.doc_byte;
            r_b_last <= w_last;
        end
        if (w_b_adv && r_b_last) begin
            r_out_data <= w_sum;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_dot_product = r_out_data;

    `PDP_ASSERT(a_no_read_over_stall, i_clk, i_rst_n, w_rd_en |-> (!r_b_valid || w_b_adv))
    `PDP_ASSERT(a_sum_cleared, i_clk, i_rst_n, (w_b_adv && r_b_last) |=> (r_sum == '0))
    `PDP_ASSERT(a_no_emit_on_stall, i_clk, i_rst_n,
        (r_out_valid && !i_ready) |-> !(w_b_adv && r_b_last))
    `PDP_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!r_out_valid && !r_b_valid))

endmodule

/* rtl/core/packed_2bit_by_4bit_dot_product.sv */
// Top level of the packed 2-bit by 4-bit dot product block.
//
// Items enter on i_valid/o_ready. With i_func low an item writes one query
// nibble (i_query_value at i_query_index); with i_func high it carries one
// packed document byte. Query stripe k lives at k*doc_length + position.
// Each document byte is paired with its four stripe nibbles and accumulated;
// the last byte of a document produces one result on o_valid/i_ready.
// The document length is written on i_cfg_valid/o_cfg_ready (always ready),
// clamped to 1 .. MAX_DOC_BYTES; the user must write it only while the block
// is idle (not enforced by the block). Throughput is one item per cycle
// unless the receiver stalls: four copies of the query store give one read
// port per 2-bit field, so all four reads run at once. o_valid rises once
// the last document byte has passed the queue and stage B into the result
// register. A stalled receiver holds the result register; the back end stops
// behind it and the two-entry queue fills before o_ready drops. Reset clears
// position, sum, queue and result; the length returns to 1. Query store
// contents are not cleared and must be written before use.
module packed_2bit_by_4bit_dot_product #(
    parameter int MAX_DOC_BYTES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_func,
    input  logic [pdp_pkg::QIDX_W-1:0] i_query_index,
    input  logic [pdp_pkg::QVAL_W-1:0] i_query_value,
    input  logic [pdp_pkg::BYTE_W-1:0] i_doc_byte,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [pdp_pkg::SUM_W-1:0]  o_dot_product,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pdp_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int LEN_W = $clog2(MAX_DOC_BYTES + 1);

    logic [LEN_W-1:0] r_len, n_len;
    logic             w_op_valid;
    pdp_pkg::t_op     w_op;
    logic             w_op_pop;
    logic [31:0]      w_cfg_wide;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wide  = 32'(i_cfg_data);

    // The length is stored already clamped.
    always_comb begin
        n_len = r_len;
        if (i_cfg_valid) begin
            if (w_cfg_wide == 32'd0) begin
                n_len = LEN_W'(1);
            end else if (w_cfg_wide > 32'(MAX_DOC_BYTES)) begin
                n_len = LEN_W'(MAX_DOC_BYTES);
            end else begin
                n_len = LEN_W'(w_cfg_wide);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
        end else begin
            r_len <= n_len;
        end
    end

    pdp_front #(
        .STORE_DEPTH (4 * MAX_DOC_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_query_index (i_query_index),
        .i_query_value (i_query_value),
        .i_doc_byte    (i_doc_byte),
        .o_op_valid    (w_op_valid),
        .o_op          (w_op),
        .i_op_pop      (w_op_pop)
    );

    pdp_back #(
        .MAX_DOC_BYTES (MAX_DOC_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_len         (r_len),
        .i_op_valid    (w_op_valid),
        .i_op          (w_op),
        .o_op_pop      (w_op_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_dot_product (o_dot_product)
    );

endmodule

/* sim/dot_product_checker.sv */
// Checker that predicts every dot product result and compares it with the block's output.
module dot_product_checker #(
    parameter int MAX_DOC_BYTES = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic                       i_func,
    input  logic [pdp_pkg::QIDX_W-1:0] i_query_index,
    input  logic [pdp_pkg::QVAL_W-1:0] i_query_value,
    input  logic [pdp_pkg::BYTE_W-1:0] i_doc_byte,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [pdp_pkg::SUM_W-1:0]  i_dot_product,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [pdp_pkg::CFG_W-1:0]  i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pdp_pkg::*;

    localparam int STORE_DEPTH = NUM_PAIRS * MAX_DOC_BYTES;

    logic [QVAL_W-1:0] query_copy [STORE_DEPTH];
    logic [CFG_W-1:0]  doc_length;
    int unsigned       byte_pos;
    logic [SUM_W-1:0]  partial_sum;
    logic [SUM_W-1:0]  expected_sums [$];

    function automatic int unsigned clamped_length(input logic [CFG_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > MAX_DOC_BYTES)
            return MAX_DOC_BYTES;
        return len;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] dot product check: %s", $time, msg);
        o_errors++;
    endtask

    // Adds the four pair-by-nibble products of one document byte and closes the
    // document when the byte sits at or past the last position of the length.
    task automatic accumulate_byte(input logic [BYTE_W-1:0] packed_byte);
        int unsigned       len;
        int unsigned       idx;
        logic [PAIR_W-1:0] pair;
        logic [SUM_W:0]    total;
        len   = clamped_length(doc_length);
        total = {1'b0, partial_sum};
        for (int k = 0; k < NUM_PAIRS; k++) begin
            pair = packed_byte[BYTE_W-1-PAIR_W*k -: PAIR_W];
            idx  = k * len + byte_pos;
            if (idx < STORE_DEPTH)
                total += pair * query_copy[idx];
        end
        if (total > SUM_MAX)
            total = SUM_MAX;
        if (byte_pos + 1 >= len) begin
            expected_sums.push_back(total[SUM_W-1:0]);
            partial_sum = '0;
            byte_pos    = 0;
        end else begin
            partial_sum = total[SUM_W-1:0];
            byte_pos++;
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        logic [SUM_W-1:0] oldest;
        if (!i_rst_n) begin
            doc_length  = 1;
            byte_pos    = 0;
            partial_sum = '0;
            expected_sums.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_sums.size() == 0) begin
                    report($sformatf("result %0d arrived with none expected", i_dot_product));
                end else begin
                    oldest = expected_sums.pop_front();
                    if (i_dot_product !== oldest)
                        report($sformatf("dot_product is %0d, expected %0d",
                                         i_dot_product, oldest));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                doc_length = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                if (i_func == FUNC_QUERY) begin
                    if (i_query_index < STORE_DEPTH)
                        query_copy[i_query_index] = i_query_value;
                end else begin
                    accumulate_byte(i_doc_byte);
                end
            end
        end
        o_pending = expected_sums.size();
    end

endmodule

/* sim/tb_packed_2bit_by_4bit_dot_product.sv */
// Testbench top: drives query writes, document bytes and lengths into the dot product block.
module tb_packed_2bit_by_4bit_dot_product;
    timeunit 1ns;
    timeprecision 1ps;
    import pdp_pkg::*;

    localparam int MAX_DOC_BYTES = 1024;
    localparam int STORE_DEPTH   = NUM_PAIRS * MAX_DOC_BYTES;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int DRAIN_CYCLES  = 6;
    localparam int FILL_ENTRIES  = 256;
    localparam int RANDOM_ITEMS  = 950;
    localparam int CYCLE_LIMIT   = 300000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_func;
    logic [QIDX_W-1:0] i_query_index;
    logic [QVAL_W-1:0] i_query_value;
    logic [BYTE_W-1:0] i_doc_byte;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [SUM_W-1:0]  o_dot_product;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data;

    int fail_count;
    int pending_count;
    int cycle_count   = 0;
    int send_idle_pct = 9;
    int recv_idle_pct = 71;
    int eff_len       = 1;
    int items_sent    = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    packed_2bit_by_4bit_dot_product #(
        .MAX_DOC_BYTES(MAX_DOC_BYTES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_query_index (i_query_index),
        .i_query_value (i_query_value),
        .i_doc_byte    (i_doc_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_dot_product (o_dot_product),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    dot_product_checker #(
        .MAX_DOC_BYTES(MAX_DOC_BYTES)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_func        (i_func),
        .i_query_index (i_query_index),
        .i_query_value (i_query_value),
        .i_doc_byte    (i_doc_byte),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_dot_product (o_dot_product),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (fail_count),
        .o_pending     (pending_count)
    );

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Valid drops only when a gap is taken, so a back-to-back item keeps it high.
    task automatic send_item(input logic f, input logic [QIDX_W-1:0] idx,
                             input logic [QVAL_W-1:0] val, input logic [BYTE_W-1:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= f;
        i_query_index <= idx;
        i_query_value <= val;
        i_doc_byte    <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic write_query(input int idx, input int val);
        send_item(FUNC_QUERY, QIDX_W'(idx), QVAL_W'(val), BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_doc_byte(input int b);
        send_item(FUNC_DOC, QIDX_W'($urandom_range(0, STORE_DEPTH - 1)),
                  QVAL_W'($urandom_range(0, 15)), BYTE_W'(b));
    endtask

    // Waits until every expected result is out and the back end has drained.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_length(input int raw);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CFG_W'(raw);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (raw == 0)
            eff_len = 1;
        else if (raw > MAX_DOC_BYTES)
            eff_len = MAX_DOC_BYTES;
        else
            eff_len = raw;
    endtask

    // One document of the current length, with query rewrites mixed in.
    // Most rewrites land in the stripes that the document reads.
    task automatic send_document(input bit full_scale, input int write_pct);
        for (int p = 0; p < eff_len; p++) begin
            if ($urandom_range(0, 99) < write_pct) begin
                if ($urandom_range(0, 3) != 0)
                    write_query($urandom_range(0, NUM_PAIRS - 1) * eff_len
                                + $urandom_range(0, eff_len - 1), $urandom_range(0, 15));
                else
                    write_query($urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, 15));
            end
            send_doc_byte(full_scale ? 8'hFF : $urandom_range(0, 255));
        end
    endtask

    initial begin : stimulus
        int rand_start;
        int done;
        int raw;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_func        = FUNC_QUERY;
        i_query_index = '0;
        i_query_value = '0;
        i_doc_byte    = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Length is one after reset, so each byte is a whole document over entries 0 to 3.
        for (int k = 0; k < NUM_PAIRS; k++)
            write_query(k, 15);
        send_doc_byte(8'hFF);
        send_doc_byte(8'h00);
        send_doc_byte(8'hC0);
        send_doc_byte(8'h1B);
        for (int k = 0; k < NUM_PAIRS; k++)
            write_query(k, 5 * k);
        send_doc_byte(8'hE4);
        write_query(STORE_DEPTH - 1, 15);
        write_query(STORE_DEPTH - 1, 0);

        // A zero length acts as one.
        set_length(0);
        send_doc_byte($urandom_range(0, 255));
        send_doc_byte($urandom_range(0, 255));

        // Fill every entry that the lengths below read: the low part of the store
        // and the head of each stripe at the largest length.
        for (int idx = 0; idx < FILL_ENTRIES; idx++)
            write_query(idx, $urandom_range(0, 15));
        for (int k = 1; k < NUM_PAIRS; k++)
            for (int p = 0; p < 4; p++)
                write_query(k * MAX_DOC_BYTES + p, $urandom_range(0, 15));

        // Full-scale bytes over the longest random length used below.
        set_length(48);
        send_document(1'b1, 0);

        // Shorten the length in the middle of a document: the next byte closes it.
        set_length(8);
        repeat (5) send_doc_byte($urandom_range(0, 255));
        set_length(3);
        send_doc_byte($urandom_range(0, 255));
        send_document(1'b0, 0);

        // An over-range length clamps to the largest document; shortening it
        // afterwards closes the document at the next byte.
        set_length(2047);
        repeat (3) send_doc_byte($urandom_range(0, 255));
        set_length(3);
        send_doc_byte($urandom_range(0, 255));

        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            done = items_sent - rand_start;
            if (done < RANDOM_ITEMS / 3) begin
                send_idle_pct = 9;
                recv_idle_pct = 71;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 71;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(0, 9))
                0: begin
                    raw = 0;
                end
                1: begin
                    raw = 1;
                end
                9: begin
                    raw = $urandom_range(13, 48);
                end
                default: begin
                    raw = $urandom_range(2, 12);
                end
            endcase
            set_length(raw);
            repeat ($urandom_range(1, 4)) send_document(1'b0, 15);
            // Leave a document unfinished now and then, so the next length change lands
            // in the middle of it.
            if (eff_len > 1 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, eff_len - 1)) send_doc_byte($urandom_range(0, 255));
        end

        settle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* packed_2bit_by_4bit_dot_product.f */
+incdir+rtl/core
rtl/core/pdp_pkg.sv
rtl/core/pdp_front.sv
rtl/core/pdp_back.sv
rtl/core/packed_2bit_by_4bit_dot_product.sv
sim/dot_product_checker.sv
sim/tb_packed_2bit_by_4bit_dot_product.sv
